// ----- rtl/core/drd_pkg.sv -----
package drd_pkg;

  localparam int unsigned TimeBits  = 40;
  localparam int unsigned InTimeBits = 32;
  localparam int unsigned RoomBits  = 4;
  localparam int unsigned TopBits   = 16;
  localparam int unsigned CfgBits   = 5;

  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};
  localparam logic [CfgBits-1:0]  RoomsReset = 5'd16;

  typedef struct packed {
    logic [InTimeBits-1:0] start_time;
    logic [InTimeBits-1:0] end_time;
  } job_t;

  typedef struct packed {
    logic [RoomBits-1:0] assigned_room;
    logic [TimeBits-1:0] finish_time;
    logic [RoomBits-1:0] top_room;
    logic [TopBits-1:0]  top_count;
    logic                order_error;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_issue;
  } sts_t;

endpackage

// ----- rtl/core/drd_ctrl.sv -----
module drd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output drd_pkg::cmd_t cmd_o,
  input  drd_pkg::sts_t sts_i
);
  import drd_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StWait   = 2'd2;
  localparam logic [1:0] StCommit = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (start_i) state_d = StScan;
      StScan:   if (sts_i.last_issue) state_d = StWait;
      StWait:   state_d = StCommit;
      StCommit: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q != StIdle);
  assign cmd_o.load    = (state_q == StIdle) && start_i;
  assign cmd_o.issue   = (state_q == StScan);
  assign cmd_o.commit  = (state_q == StCommit);

endmodule

// ----- rtl/core/drd_datapath.sv -----
module drd_datapath #(
  parameter int unsigned MAX_ROOMS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  drd_pkg::cmd_t                cmd_i,
  output drd_pkg::sts_t                sts_o,
  input  drd_pkg::job_t                job_i,
  input  logic                         cfg_we_i,
  input  logic [drd_pkg::CfgBits-1:0]  cfg_data_i,
  output drd_pkg::result_t             result_o,
  output logic                         result_valid_o
);
  import drd_pkg::*;

  localparam int unsigned RIdx = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // room table
  logic [TimeBits-1:0]   free_mem [MAX_ROOMS];
  logic [COUNT_BITS-1:0] book_mem [MAX_ROOMS];
  logic [MAX_ROOMS-1:0]  vld_q;

  logic [CfgBits-1:0]    rooms_q;
  logic [InTimeBits-1:0] last_start_q;
  logic [InTimeBits-1:0] st_q, en_q;
  logic                  err_q;

  logic [RIdx-1:0]       addr_q;
  logic [RIdx-1:0]       rd_idx_q;
  logic                  rd_valid_q;
  logic [TimeBits-1:0]   rd_free_q;
  logic [COUNT_BITS-1:0] rd_book_q;
  logic                  rd_vld_q;

  logic                  found_q;
  logic [RIdx-1:0]       fr_idx_q;
  logic [COUNT_BITS-1:0] fr_cnt_q;
  logic [RIdx-1:0]       mn_idx_q;
  logic [TimeBits-1:0]   mn_free_q;
  logic [COUNT_BITS-1:0] mn_cnt_q;
  logic [RIdx-1:0]       tp_idx_q;
  logic [COUNT_BITS-1:0] tp_cnt_q;

  result_t               res_q;
  logic                  res_valid_q;

  // active room count clamped to 1..MAX_ROOMS, as a last index
  logic [6:0] last_idx;
  always_comb begin
    if (rooms_q == '0) begin
      last_idx = 7'd0;
    end else if ({2'b00, rooms_q} > 7'(MAX_ROOMS)) begin
      last_idx = 7'(MAX_ROOMS - 1);
    end else begin
      last_idx = {2'b00, rooms_q} - 7'd1;
    end
  end

  assign sts_o.last_issue = (7'(addr_q) == last_idx);

  // entry that is not yet written reads as zero
  logic [TimeBits-1:0]   ent_free;
  logic [COUNT_BITS-1:0] ent_book;
  assign ent_free = rd_vld_q ? rd_free_q : '0;
  assign ent_book = rd_vld_q ? rd_book_q : '0;

  logic first_ent;
  assign first_ent = (rd_idx_q == '0);

  // commit decision
  logic [RIdx-1:0]       room;
  logic [COUNT_BITS-1:0] cnt_old, cnt_new;
  logic [InTimeBits-1:0] dur;
  logic [TimeBits:0]     sum;
  logic [TimeBits-1:0]   finish;
  logic [RIdx-1:0]       top_idx;
  logic [COUNT_BITS-1:0] top_cnt;
  logic [31:0]           room_w, top_w, top_cnt_w;

  always_comb begin
    room    = found_q ? fr_idx_q : mn_idx_q;
    cnt_old = found_q ? fr_cnt_q : mn_cnt_q;
    cnt_new = (cnt_old == CountMax) ? cnt_old : cnt_old + COUNT_BITS'(1);
    dur     = en_q - st_q;
    sum     = {1'b0, mn_free_q} + (TimeBits+1)'(dur);
    if (found_q) begin
      finish = TimeBits'(en_q);
    end else if (sum[TimeBits]) begin
      finish = TimeMax;
    end else begin
      finish = sum[TimeBits-1:0];
    end
    top_idx = tp_idx_q;
    top_cnt = tp_cnt_q;
    if (!err_q) begin
      if (room == tp_idx_q || cnt_new > tp_cnt_q ||
          (cnt_new == tp_cnt_q && room < tp_idx_q)) begin
        top_idx = room;
        top_cnt = cnt_new;
      end
    end
    room_w    = 32'(room);
    top_w     = 32'(top_idx);
    top_cnt_w = 32'(top_cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rooms_q      <= RoomsReset;
      last_start_q <= '0;
      vld_q        <= '0;
      addr_q       <= '0;
      rd_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) rooms_q <= cfg_data_i;
      rd_valid_q  <= cmd_i.issue;
      res_valid_q <= cmd_i.commit;
      if (cmd_i.load) begin
        addr_q  <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.issue) addr_q <= addr_q + RIdx'(1);
      if (rd_valid_q && !found_q && ent_free <= TimeBits'(st_q)) found_q <= 1'b1;
      if (cmd_i.commit && !err_q) begin
        vld_q[room]  <= 1'b1;
        last_start_q <= st_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_q  <= job_i.start_time;
      en_q  <= job_i.end_time;
      err_q <= (job_i.start_time < last_start_q) ||
               (job_i.end_time <= job_i.start_time);
    end
    if (cmd_i.issue) begin
      rd_free_q <= free_mem[addr_q];
      rd_book_q <= book_mem[addr_q];
      rd_vld_q  <= vld_q[addr_q];
      rd_idx_q  <= addr_q;
    end
    if (cmd_i.commit && !err_q) begin
      free_mem[room] <= finish;
      book_mem[room] <= cnt_new;
    end
  end

  // scan accumulators and result register
  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      if (!found_q && ent_free <= TimeBits'(st_q)) begin
        fr_idx_q <= rd_idx_q;
        fr_cnt_q <= ent_book;
      end
      if (first_ent || ent_free < mn_free_q) begin
        mn_idx_q  <= rd_idx_q;
        mn_free_q <= ent_free;
        mn_cnt_q  <= ent_book;
      end
      if (first_ent || ent_book > tp_cnt_q) begin
        tp_idx_q <= rd_idx_q;
        tp_cnt_q <= ent_book;
      end
    end
    if (cmd_i.commit) begin
      res_q.order_error   <= err_q;
      res_q.assigned_room <= err_q ? '0 : room_w[RoomBits-1:0];
      res_q.finish_time   <= err_q ? '0 : finish;
      res_q.top_room      <= top_w[RoomBits-1:0];
      res_q.top_count     <= (top_cnt_w > 32'h0000_FFFF) ? 16'hFFFF
                                                         : top_cnt_w[TopBits-1:0];
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule

// ----- rtl/core/delayed_room_dispatcher.sv -----
// delayed room dispatcher: books jobs into rooms, earliest-free room when all busy
//
// input: pulse start with job_i (start and end time) while busy is low; the job
// is taken at that edge. jobs must come in nondecreasing start order with end
// after start, otherwise the result flags order_error and nothing changes.
// output: one result per job, shown on result_o for a single cycle with
// result_valid_o high. the receiver cannot stall and must take it then.
// config: cfg_we_i writes cfg_data_i into the active room count; the user must
// write it only while idle, which the block itself does not enforce.
// timing: after the accepting edge the block is busy while it reads the n active
// rooms through the table's single read port, one room a cycle, then while it takes
// in the last read beat, and then while it decides and writes back. the result beat
// follows in the next cycle, when busy is low again and a new job can be taken.
//
// reset: end times and booking counts clear at once through per-room valid bits;
// the last start clears and the room count returns to sixteen. no clearing pass.
module delayed_room_dispatcher #(
  parameter int unsigned MAX_ROOMS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  drd_pkg::job_t               job_i,
  input  logic                        cfg_we_i,
  input  logic [drd_pkg::CfgBits-1:0] cfg_data_i,
  output drd_pkg::result_t            result_o,
  output logic                        result_valid_o
);
  import drd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  drd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  drd_datapath #(
    .MAX_ROOMS  (MAX_ROOMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .job_i          (job_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// ----- rtl/core/drd_checker.sv -----
module drd_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input drd_pkg::result_t result_o,
  input logic             result_valid_o
);
  import drd_pkg::*;

  // a taken job keeps the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("job taken but busy not raised");

  // result beats are spaced by the table walk
  a_beat_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beats back to back");

  // rejected job reports no booking
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.order_error |->
      result_o.assigned_room == '0 && result_o.finish_time == '0)
    else $error("rejected job carries a booking");

  // an accepted booking makes some room count nonzero
  a_top_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.order_error |-> result_o.top_count != '0)
    else $error("top count zero after a booking");

  // a result only appears once the job's work is done
  a_beat_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result beat without a job in work");

endmodule

bind delayed_room_dispatcher drd_checker u_drd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_o       (result_o),
  .result_valid_o (result_valid_o)
);

// ----- tb/delayed_room_dispatcher_tb.sv -----
module delayed_room_dispatcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drd_pkg::*;

  localparam int unsigned NumRooms    = 16;
  localparam int unsigned WatchLimit  = 4000;
  localparam int unsigned DrainSettle = 20;
  localparam int unsigned EndSettle   = 24;
  localparam int unsigned MaxPrints   = 40;

  typedef enum logic [1:0] {
    BeatJob,
    BeatCfg,
    BeatDrain
  } beat_kind_e;

  typedef struct {
    beat_kind_e        kind;
    job_t              job;
    logic [CfgBits-1:0] cfg;
    int unsigned       gap_pct;
  } pending_beat_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  job_t               job = '0;
  logic               cfg_we = 1'b0;
  logic [CfgBits-1:0] cfg_data = '0;
  result_t            result;
  logic               result_valid;

  delayed_room_dispatcher DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .job_i         (job),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .result_o      (result),
    .result_valid_o(result_valid)
  );

  // mirror of the room table
  logic [CfgBits-1:0]    active_cfg = RoomsReset;
  logic [TimeBits-1:0]   room_free_q  [NumRooms];
  logic [TopBits-1:0]    room_count_q [NumRooms];
  logic [InTimeBits-1:0] last_start_q = '0;

  pending_beat_t job_backlog[$];
  result_t       predicted_bookings[$];
  int unsigned   mismatch_count = 0;
  int unsigned   settle_cnt = 0;
  int unsigned   quiet_cycles = 0;
  logic [31:0]   gen_now = '0;

  initial begin
    for (int i = 0; i < NumRooms; i++) begin
      room_free_q[i]  = '0;
      room_count_q[i] = '0;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic result_t book_job(job_t j);
    result_t             r;
    int unsigned         n;
    int unsigned         pick;
    int unsigned         best;
    bit                  found;
    logic [TimeBits-1:0] dur;
    r = '0;
    n = (active_cfg == 0) ? 1 : ((active_cfg > NumRooms) ? NumRooms : int'(active_cfg));
    if (j.start_time < last_start_q || j.end_time <= j.start_time) begin
      r.order_error = 1'b1;
    end else begin
      found = 1'b0;
      pick  = 0;
      for (int i = 0; i < n; i++) begin
        if (!found && room_free_q[i] <= {8'b0, j.start_time}) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.finish_time = {8'b0, j.end_time};
      end else begin
        // every room taken: queue behind the earliest to free up
        dur  = {8'b0, j.end_time} - {8'b0, j.start_time};
        pick = 0;
        for (int i = 1; i < n; i++) begin
          if (room_free_q[i] < room_free_q[pick]) pick = i;
        end
        if (room_free_q[pick] > TimeMax - dur) r.finish_time = TimeMax;
        else r.finish_time = room_free_q[pick] + dur;
      end
      room_free_q[pick] = r.finish_time;
      if (room_count_q[pick] != {TopBits{1'b1}})
        room_count_q[pick] = room_count_q[pick] + TopBits'(1);
      last_start_q    = j.start_time;
      r.assigned_room = pick[RoomBits-1:0];
    end
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (room_count_q[i] > room_count_q[best]) best = i;
    end
    r.top_room  = best[RoomBits-1:0];
    r.top_count = room_count_q[best];
    return r;
  endfunction

  function automatic job_t make_job(logic [31:0] s, logic [31:0] e);
    job_t j;
    j.start_time = s;
    j.end_time   = e;
    return j;
  endfunction

  // mostly in-order jobs; noise_pct of them out of order or ending at or before start
  function automatic job_t random_job(int unsigned step_max, int unsigned noise_pct);
    job_t        j;
    logic [31:0] headroom;
    logic [31:0] dur;
    logic [31:0] back;
    int unsigned sel;
    if ($urandom_range(99) < noise_pct) begin
      if ($urandom_range(1) == 1 && gen_now != 0) begin
        back = $urandom_range(500, 1);
        if (back > gen_now) back = gen_now;
        j.start_time = gen_now - back;
        j.end_time   = j.start_time + 1 + $urandom_range(100);
      end else begin
        j.start_time = gen_now + $urandom_range(100);
        sel = $urandom_range(3);
        if (sel == 0) j.end_time = j.start_time;
        else if (sel == 1) j.end_time = '0;
        else begin
          back = $urandom_range(50, 1);
          if (back > j.start_time) back = j.start_time;
          j.end_time = j.start_time - back;
        end
      end
      return j;
    end
    if (gen_now < 32'hD000_0000 && $urandom_range(99) < 2) gen_now = gen_now + $urandom_range(1 << 24);
    else gen_now = gen_now + $urandom_range(step_max);
    j.start_time = gen_now;
    headroom = 32'hFFFF_FFFF - gen_now;
    sel = $urandom_range(99);
    if (sel < 60) dur = $urandom_range(64, 1);
    else if (sel < 90) dur = $urandom_range(4096, 65);
    else dur = $urandom();
    if (dur > headroom) dur = headroom;
    if (dur == 0) dur = 1;
    j.end_time = gen_now + dur;
    return j;
  endfunction

  task automatic push_job(job_t j, int unsigned gap);
    pending_beat_t b;
    b.kind    = BeatJob;
    b.job     = j;
    b.cfg     = '0;
    b.gap_pct = gap;
    job_backlog.push_back(b);
  endtask

  task automatic push_drain();
    pending_beat_t b;
    b.kind    = BeatDrain;
    b.job     = '0;
    b.cfg     = '0;
    b.gap_pct = 0;
    job_backlog.push_back(b);
  endtask

  // room count only changes once the block has gone quiet
  task automatic push_cfg(logic [CfgBits-1:0] v);
    pending_beat_t b;
    push_drain();
    b.kind    = BeatCfg;
    b.job     = '0;
    b.cfg     = v;
    b.gap_pct = 0;
    job_backlog.push_back(b);
  endtask

  task automatic push_random(int unsigned count, int unsigned gap, int unsigned step_max);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(99) == 0) push_drain();
      push_job(random_job(step_max, 15), gap);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrints)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(posedge clk_i) begin : drive
    pending_beat_t head;
    logic          drive_start;
    logic          drive_we;
    logic          idle_now;
    if (!rst_ni) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      if (start && !busy) predicted_bookings.push_back(book_job(job));
      if (cfg_we) active_cfg = cfg_data;
      drive_start = start && busy;
      drive_we    = 1'b0;
      idle_now    = !start && !busy && !cfg_we && !result_valid &&
                    predicted_bookings.size() == 0;
      if (!drive_start && job_backlog.size() != 0) begin
        head = job_backlog[0];
        case (head.kind)
          BeatJob: begin
            if ($urandom_range(99) >= head.gap_pct) begin
              job         <= head.job;
              drive_start = 1'b1;
              void'(job_backlog.pop_front());
            end
          end
          BeatCfg: begin
            if (idle_now) begin
              cfg_data <= head.cfg;
              drive_we = 1'b1;
              void'(job_backlog.pop_front());
            end
          end
          default: begin
            if (settle_cnt != 0) begin
              settle_cnt--;
              if (settle_cnt == 0) void'(job_backlog.pop_front());
            end else if (idle_now) begin
              settle_cnt = DrainSettle;
            end
          end
        endcase
      end
      start  <= drive_start;
      cfg_we <= drive_we;
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_results
    result_t want;
    if (rst_ni && result_valid) begin
      if (predicted_bookings.size() == 0) begin
        report_mismatch("result beat with nothing pending", result[63:0], '0);
      end else begin
        want = predicted_bookings.pop_front();
        if (result.assigned_room !== want.assigned_room)
          report_mismatch("assigned_room", 64'(result.assigned_room),
                          64'(want.assigned_room));
        if (result.finish_time !== want.finish_time)
          report_mismatch("finish_time", 64'(result.finish_time), 64'(want.finish_time));
        if (result.top_room !== want.top_room)
          report_mismatch("top_room", 64'(result.top_room), 64'(want.top_room));
        if (result.top_count !== want.top_count)
          report_mismatch("top_count", 64'(result.top_count), 64'(want.top_count));
        if (result.order_error !== want.order_error)
          report_mismatch("order_error", 64'(result.order_error), 64'(want.order_error));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // directed: field extremes, both reject cases, delays, boundary, room count edges
    push_job(make_job(32'd0, 32'd1), 35);
    push_job(make_job(32'd0, 32'hFFFF_FFFF), 35);
    push_job(make_job(32'd0, 32'd0), 35);
    push_job(make_job(32'd5, 32'd3), 35);
    push_job(make_job(32'hFFFF_FFFF, 32'hFFFF_FFFF), 35);
    push_job(make_job(32'd10, 32'd20), 35);
    push_job(make_job(32'd3, 32'd9), 35);
    push_job(make_job(32'd10, 32'd0), 35);
    push_cfg(5'd2);
    push_job(make_job(32'd12, 32'd13), 35);
    push_job(make_job(32'd12, 32'd14), 35);
    push_cfg(5'd1);
    push_job(make_job(32'd15, 32'd16), 35);
    push_cfg(5'd0);
    push_job(make_job(32'd15, 32'd20), 35);
    push_cfg(5'd31);
    push_job(make_job(32'd30, 32'd40), 35);
    push_job(make_job(32'd30, 32'd35), 35);
    push_job(make_job(32'd30, 32'd31), 35);
    push_cfg(5'd16);
    push_job(make_job(32'd31, 32'd32), 35);
    push_job(make_job(32'd32, 32'h8000_0000), 35);
    push_cfg(5'd17);
    push_job(make_job(32'd32, 32'd33), 35);
    gen_now = 32'd32;

    push_cfg(5'd4);
    push_random(300, 35, 20);

    // one room, near-full-range jobs: the delayed finish runs into saturation
    push_cfg(5'd1);
    for (int k = 0; k < 280; k++) begin
      gen_now = gen_now + $urandom_range(3);
      push_job(make_job(gen_now, 32'hFFFF_FFFF - $urandom_range(1000)), 35);
    end

    push_cfg(5'd16);
    push_random(250, 76, 8);
    push_cfg(5'd0);
    push_random(60, 76, 20);

    push_cfg(5'd31);
    push_random(300, 0, 30);
    if (gen_now < 32'hC000_0000) gen_now = 32'hC000_0000;
    push_cfg(5'($urandom_range(15, 2)));
    push_random(100, 0, 20);
    push_cfg(5'd3);
    push_random(60, 0, 20);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (job_backlog.size() != 0 || start || predicted_bookings.size() != 0 || result_valid)
      @(negedge clk_i);
    repeat (EndSettle) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
